// ===== src/cdq_pkg.sv =====
package cdq_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int VALUE_W       = 31;
  localparam int POP_W         = 32;
  localparam int OCC_W         = 11;

  localparam logic [POP_W-1:0] POP_NONE = '1;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    status_t           status;
    logic [OCC_W-1:0]  occupancy;
  } cmd_ctrl_t;

endpackage

// ===== src/cdq_front.sv =====
module cdq_front #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  cdq_pkg::op_t                      op,
  input  logic [cdq_pkg::VALUE_W-1:0]       push_value,
  output logic                              cmd_valid,
  input  logic                              cmd_full,
  output cdq_pkg::cmd_ctrl_t                cmd_ctrl,
  output logic [$clog2(DEPTH)-1:0]          cmd_addr,
  output logic [cdq_pkg::VALUE_W-1:0]       cmd_wdata
);
  import cdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] front_ptr, front_ptr_next;
  logic [AW-1:0] back_ptr, back_ptr_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic          accept, full, empty;

  assign req_stall = cmd_full;
  assign accept    = req_valid && !cmd_full;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  // pointers wrap at any depth, not just powers of two
  assign front_inc = (front_ptr == AW'(DEPTH - 1)) ? '0 : front_ptr + AW'(1);
  assign front_dec = (front_ptr == '0) ? AW'(DEPTH - 1) : front_ptr - AW'(1);
  assign back_inc  = (back_ptr == AW'(DEPTH - 1)) ? '0 : back_ptr + AW'(1);
  assign back_dec  = (back_ptr == '0) ? AW'(DEPTH - 1) : back_ptr - AW'(1);

  always_comb begin
    front_ptr_next  = front_ptr;
    back_ptr_next   = back_ptr;
    count_next      = count;
    cmd_ctrl.kind   = CMD_NONE;
    cmd_ctrl.status = ST_OK;
    cmd_addr        = front_ptr;
    unique case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          cmd_ctrl.status = ST_FULL;
        end else begin
          cmd_ctrl.kind  = CMD_WRITE;
          cmd_addr       = front_dec;
          front_ptr_next = front_dec;
          count_next     = count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          cmd_ctrl.status = ST_EMPTY;
        end else begin
          cmd_ctrl.kind  = CMD_READ;
          cmd_addr       = front_ptr;
          front_ptr_next = front_inc;
          count_next     = count - CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          cmd_ctrl.status = ST_FULL;
        end else begin
          cmd_ctrl.kind = CMD_WRITE;
          cmd_addr      = back_ptr;
          back_ptr_next = back_inc;
          count_next    = count + CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          cmd_ctrl.status = ST_EMPTY;
        end else begin
          cmd_ctrl.kind = CMD_READ;
          cmd_addr      = back_dec;
          back_ptr_next = back_dec;
          count_next    = count - CW'(1);
        end
      end
      default: begin
        cmd_ctrl.kind = CMD_NONE;
      end
    endcase
    cmd_ctrl.occupancy = OCC_W'(count_next);
  end

  assign cmd_valid = accept;
  assign cmd_wdata = push_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr <= '0;
      back_ptr  <= '0;
      count     <= '0;
    end else if (accept) begin
      front_ptr <= front_ptr_next;
      back_ptr  <= back_ptr_next;
      count     <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_ctrl.kind == CMD_WRITE |=> count == $past(count) + CW'(1))
    else $error("accepted push did not grow the count");

endmodule

// ===== src/cdq_cmd_fifo.sv =====
module cdq_cmd_fifo #(
  parameter int AW = $clog2(cdq_pkg::DEPTH_DEFAULT)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_valid,
  output logic                         full,
  input  cdq_pkg::cmd_ctrl_t           wr_ctrl,
  input  logic [AW-1:0]                wr_addr,
  input  logic [cdq_pkg::VALUE_W-1:0]  wr_wdata,
  output logic                         rd_valid,
  input  logic                         rd_take,
  output cdq_pkg::cmd_ctrl_t           rd_ctrl,
  output logic [AW-1:0]                rd_addr,
  output logic [cdq_pkg::VALUE_W-1:0]  rd_wdata
);
  import cdq_pkg::*;

  cmd_ctrl_t          ctrl_q  [2];
  logic [AW-1:0]      addr_q  [2];
  logic [VALUE_W-1:0] wdata_q [2];
  logic               wr_ptr, rd_ptr;
  logic [1:0]         count;
  logic               push, pop;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && !full;
  assign pop      = rd_take && rd_valid;

  assign rd_ctrl  = ctrl_q[rd_ptr];
  assign rd_addr  = addr_q[rd_ptr];
  assign rd_wdata = wdata_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_q[wr_ptr]  <= wr_ctrl;
      addr_q[wr_ptr]  <= wr_addr;
      wdata_q[wr_ptr] <= wr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("command queue overfilled");

endmodule

// ===== src/cdq_back.sv =====
module cdq_back #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_take,
  input  cdq_pkg::cmd_ctrl_t                cmd_ctrl,
  input  logic [$clog2(DEPTH)-1:0]          cmd_addr,
  input  logic [cdq_pkg::VALUE_W-1:0]       cmd_wdata,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic signed [cdq_pkg::POP_W-1:0]  pop_value,
  output cdq_pkg::status_t                  status,
  output logic [cdq_pkg::OCC_W-1:0]         occupancy
);
  import cdq_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data;
  logic               is_read;
  logic               issue;

  // a command goes to the store only when the result slot frees up
  assign issue    = cmd_valid && (!rsp_valid || !rsp_stall);
  assign cmd_take = issue;

  always_ff @(posedge clk) begin
    if (issue && cmd_ctrl.kind == CMD_WRITE) begin
      mem[cmd_addr] <= cmd_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && cmd_ctrl.kind == CMD_READ) begin
      rd_data <= mem[cmd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (issue) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      is_read   <= (cmd_ctrl.kind == CMD_READ);
      status    <= cmd_ctrl.status;
      occupancy <= cmd_ctrl.occupancy;
    end
  end

  assign pop_value = is_read ? $signed({1'b0, rd_data}) : $signed(POP_NONE);

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rd_data === $past(rd_data))
    else $error("read data moved under a stalled result");

  a_no_issue_blocked: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("stalled result dropped");

endmodule

// ===== src/circular_deque_core.sv =====
// channel   | valid     | stall     | payload
// ----------+-----------+-----------+--------------------------------
// request   | req_valid | req_stall | op, push_value
// response  | rsp_valid | rsp_stall | pop_value, status, occupancy
//
// one request per cycle while req_stall is low; each request is classified by the
// front, held in the command queue, then registered by one store access
// the store is a single-port array: one write or one registered read a cycle
// a two-entry command queue parts the front from the store side
// rst is synchronous; pointers and count clear, store contents stay unknown
// response stalls back up through the queue to req_stall
module circular_deque_core #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  cdq_pkg::op_t                      op,
  input  logic [cdq_pkg::VALUE_W-1:0]       push_value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic signed [cdq_pkg::POP_W-1:0]  pop_value,
  output cdq_pkg::status_t                  status,
  output logic [cdq_pkg::OCC_W-1:0]         occupancy
);
  import cdq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic               fe_valid, q_full;
  cmd_ctrl_t          fe_ctrl;
  logic [AW-1:0]      fe_addr;
  logic [VALUE_W-1:0] fe_wdata;

  logic               q_valid, q_take;
  cmd_ctrl_t          q_ctrl;
  logic [AW-1:0]      q_addr;
  logic [VALUE_W-1:0] q_wdata;

  cdq_front #(.DEPTH(DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .op         (op),
    .push_value (push_value),
    .cmd_valid  (fe_valid),
    .cmd_full   (q_full),
    .cmd_ctrl   (fe_ctrl),
    .cmd_addr   (fe_addr),
    .cmd_wdata  (fe_wdata)
  );

  cdq_cmd_fifo #(.AW(AW)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fe_valid),
    .full     (q_full),
    .wr_ctrl  (fe_ctrl),
    .wr_addr  (fe_addr),
    .wr_wdata (fe_wdata),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_ctrl  (q_ctrl),
    .rd_addr  (q_addr),
    .rd_wdata (q_wdata)
  );

  cdq_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_take  (q_take),
    .cmd_ctrl  (q_ctrl),
    .cmd_addr  (q_addr),
    .cmd_wdata (q_wdata),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .pop_value (pop_value),
    .status    (status),
    .occupancy (occupancy)
  );

endmodule
